>>> src/integer_to_decimal_ascii_core_defines.svh
// Assertion helpers shared by the RTL files of the decimal text converter.
// Every property is sampled on the rising edge of clk and is disabled while rst_n is low.
`ifndef INTEGER_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define I2DA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("i2da assertion failed");
`define I2DA_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("i2da forbidden condition seen");
`else
`define I2DA_ASSERT(label, prop)
`define I2DA_ASSERT_NEVER(label, cond)
`endif

`endif

>>> src/i2da_pkg.sv
`default_nettype none

package i2da_pkg;

    localparam int VALUE_W  = 64;
    localparam int DIGITS   = 20;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CNT_W    = 6;
    localparam int DCNT_W   = 5;

    localparam logic [CNT_W-1:0]  BIT_CNT_LAST = 6'd63;
    localparam logic [DCNT_W-1:0] NUM_DIGITS   = 5'd20;
    localparam logic [7:0]        ASCII_MINUS  = 8'd45;
    localparam logic [7:0]        ASCII_ZERO   = 8'd48;
    localparam logic [3:0]        BCD_ADJ_MIN  = 4'd5;
    localparam logic [3:0]        BCD_ADJ_ADD  = 4'd3;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

endpackage

`default_nettype wire

>>> src/i2da_dabble.sv
`default_nettype none
`include "integer_to_decimal_ascii_core_defines.svh"

module i2da_dabble (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [i2da_pkg::VALUE_W-1:0]  magnitude,
    output i2da_pkg::dab_status_t              status,
    output logic      [i2da_pkg::BCD_W-1:0]    bcd
);
    import i2da_pkg::*;

    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    // Add three to every digit of five or more before the shift, so the
    // shifted digit carries into its neighbor as a decimal digit should.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= BCD_ADJ_MIN)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + BCD_ADJ_ADD;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = magnitude;
            bcd_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next   = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

    `I2DA_ASSERT_NEVER(a_no_start_when_busy, start && busy_reg)
    `I2DA_ASSERT(a_done_after_last_bit, (busy_reg && !start && cnt_reg == BIT_CNT_LAST) |=> done_reg)
    `I2DA_ASSERT(a_done_single_pulse, done_reg |=> !done_reg)

endmodule

`default_nettype wire

>>> src/integer_to_decimal_ascii_core.sv
// Decimal text converter: one 64-bit integer in, its ASCII decimal digits out.
// Input channel: in_valid / in_ready with the value port. A transaction is taken
// only while the block is idle; in_ready stays low until the last byte of the
// number has been loaded into the output register.
// Output channel: out_valid / out_ready with text_byte and last_byte, one byte per
// transaction, most significant digit first, a leading '-' for negative values in
// signed mode, last_byte high on the final digit.
// Configuration: cfg_wr_en writes cfg_wr_data into signed_mode (reset value 1).
// Conversion: a shift-and-add-3 converter takes one input bit per cycle over 64
// passes, and its digits are then loaded into the sequencer. The sequencer drops
// the leading zero digits one at a time (up to 19 of them), picks the first byte
// and then emits one digit per output byte; skipped and emitted digits always
// sum to 20.
// A stalled receiver holds the current byte in the output register and the
// sequencer waits; nothing is dropped. The final byte may still wait there
// while the next value is accepted.
// Reset clears the sequencer and the output valid flag and sets signed mode.
`default_nettype none
`include "integer_to_decimal_ascii_core_defines.svh"

module integer_to_decimal_ascii_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [i2da_pkg::VALUE_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [7:0]                    text_byte,
    output logic                               last_byte
);
    import i2da_pkg::*;

    state_t              state_reg, state_next;
    logic                signed_mode_reg;
    logic                neg_reg, neg_next;
    logic [BCD_W-1:0]    digits_reg, digits_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          text_byte_reg, text_byte_next;
    logic                last_byte_reg, last_byte_next;

    logic                in_fire;
    logic                out_free;
    logic                is_neg;
    logic [VALUE_W-1:0]  magnitude;
    logic [3:0]          top_digit;
    dab_status_t         dab_status;
    logic [BCD_W-1:0]    dab_bcd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_neg    = signed_mode_reg && value[VALUE_W-1];
    assign magnitude = is_neg ? (~value + 1'b1) : value;
    assign top_digit = digits_reg[BCD_W-1 -: 4];

    i2da_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .magnitude (magnitude),
        .status    (dab_status),
        .bcd       (dab_bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        digits_next    = digits_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        text_byte_next = text_byte_reg;
        last_byte_next = last_byte_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next   = is_neg;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (dab_status.done)
                begin
                    digits_next = dab_bcd;
                    dcnt_next   = NUM_DIGITS;
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, but always keep the units digit.
                if (top_digit == 4'd0 && dcnt_reg != 5'd1)
                begin
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    dcnt_next   = dcnt_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    text_byte_next = ASCII_MINUS;
                    last_byte_next = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    text_byte_next = ASCII_ZERO + {4'd0, top_digit};
                    last_byte_next = (dcnt_reg == 5'd1);
                    digits_next    = {digits_reg[BCD_W-5:0], 4'd0};
                    dcnt_next      = dcnt_reg - 1'b1;
                    if (dcnt_reg == 5'd1)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            signed_mode_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                signed_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        digits_reg    <= digits_next;
        dcnt_reg      <= dcnt_next;
        text_byte_reg <= text_byte_next;
        last_byte_reg <= last_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign text_byte = text_byte_reg;
    assign last_byte = last_byte_reg;

    `I2DA_ASSERT(a_accept_starts_conv, in_fire |=> (state_reg == ST_CONV))
    `I2DA_ASSERT(a_sign_only_negative, (state_reg == ST_SIGN) |-> neg_reg)
    `I2DA_ASSERT_NEVER(a_emit_with_no_digits, (state_reg == ST_EMIT) && (dcnt_reg == 5'd0))

endmodule

`default_nettype wire
